>>> sv/pcit_pkg.sv
// Shared types and constants for the polygon cell inclusion test.
// No dependencies; imported by polygon_cell_inclusion_test.
`timescale 1ns / 1ps

package pcit_pkg;

    localparam int MAX_VERTICES = 64;
    localparam int VIDX_W       = $clog2(MAX_VERTICES);
    localparam int VCNT_W       = $clog2(MAX_VERTICES + 1);

    localparam int COORD_W      = 24;
    localparam int CELL_W       = 12;
    localparam int WIDTH_W      = 16;
    localparam int COUNT_W      = 7;
    localparam int CFG_IDX_W    = 2;

    // doubled cell centre: (2i+1) * dx
    localparam int CTR_W        = CELL_W + 1 + WIDTH_W;
    // multiplier operands and the cross products
    localparam int OPND_W       = 32;
    localparam int PROD_W       = CTR_W + COORD_W + 2;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    localparam logic [CFG_IDX_W-1:0] CFG_CELL_WIDTH_X = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_CELL_WIDTH_Y = CFG_IDX_W'(1);

    localparam logic [WIDTH_W-1:0] CELL_WIDTH_RESET = WIDTH_W'(256);

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TEST = 1'b1;

    typedef struct packed {
        logic               operation;
        logic [COORD_W-1:0] vertex_x;
        logic [COORD_W-1:0] vertex_y;
        logic               first_vertex;
        logic [CELL_W-1:0]  cell_i;
        logic [CELL_W-1:0]  cell_j;
    } item_t;

    typedef struct packed {
        logic               inside_res;
        logic [COUNT_W-1:0] crossing_count;
        logic               list_overflow;
    } result_t;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
    } vertex_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CX,
        ST_CY,
        ST_RESTART,
        ST_MUL_L,
        ST_MUL_R,
        ST_CMP,
        ST_DONE
    } state_t;

endpackage

>>> sv/pcit_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module pcit_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> sv/polygon_cell_inclusion_test.sv
// Polygon cell inclusion test: top level, sequencer and shared multiplier.
// Depends on pcit_pkg and pcit_ram.
`timescale 1ns / 1ps

// Usage
// -----
// item channel (item_valid / item_stall / item): one transaction is either a
// vertex load (operation = OP_LOAD) or a cell test (operation = OP_TEST).
// A load is absorbed in its accept cycle and gives no result. first_vertex
// restarts the list and clears the overflow flag. Loads past MAX_VERTICES
// are dropped and set the overflow flag.
// A test walks the stored rings edge by edge and returns one transaction on
// the result channel (result_valid / result_stall / result).
// Test sequence: the cell centre (ST_CX, ST_CY), then ST_RESTART at each
// ring start, ST_MUL_L, ST_MUL_R and ST_CMP for each edge, and ST_DONE to
// hand over; with fewer than two stored vertices no edge is walked. The
// single multiplier forms the centre and both cross products of every edge
// in turn. item_stall is high for the whole test.
// If result_stall holds the previous result, the finished test waits in the
// hand-over state; a load or the next test is taken once the result moves.
// cfg channel: cfg_ready is always high; index 0 is cell_width_x, index 1
// cell_width_y, other indexes are ignored. Write only while idle.
// Reset: spacings return to 256 (1.0 m), list empty, overflow clear, no
// result pending. Vertex storage is not cleared.

module polygon_cell_inclusion_test
    import pcit_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 item_valid,
    output logic                 item_stall,
    input  item_t                item,

    output logic                 result_valid,
    input  logic                 result_stall,
    output result_t              result,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WIDTH_W-1:0]   cfg_data
);

    // configuration
    logic [WIDTH_W-1:0] width_x_reg, width_y_reg;

    // list bookkeeping
    logic [VCNT_W-1:0]  total_reg, total_next;
    logic               ovf_reg, ovf_next;

    // sequencer
    state_t             state_reg, state_next;
    logic [CELL_W-1:0]  ci_reg, ci_next, cj_reg, cj_next;
    logic [CTR_W-1:0]   cx_reg, cx_next, cy_reg, cy_next;
    logic [VCNT_W-1:0]  v_reg, v_next;          // index of edge start vertex
    vertex_t            a_reg, a_next;          // edge start vertex
    vertex_t            start_reg, start_next;  // current ring's first vertex
    logic signed [PROD_W-1:0] lhs_reg, lhs_next, rhs_reg, rhs_next;
    logic               straddle_reg, straddle_next;
    logic               rising_reg, rising_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               parity_reg, parity_next;

    // result register
    logic               res_valid_reg, res_valid_next;
    result_t            res_reg, res_next;

    // vertex memory ports
    logic               wr_en, rd_en;
    logic [VIDX_W-1:0]  wr_addr, rd_addr;
    vertex_t            wr_data, rd_data;

    // shared multiplier
    logic signed [OPND_W-1:0]   mul_a, mul_b;
    logic signed [2*OPND_W-1:0] mul_p;

    logic               item_acc;
    logic               crossed;
    logic [VCNT_W-1:0]  b_idx, skip_idx, last_idx;
    logic [CTR_W-1:0]   ay2, by2;

    pcit_ram #(
        .WIDTH ($bits(vertex_t)),
        .DEPTH (MAX_VERTICES)
    ) u_vertex_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign item_stall   = (state_reg != ST_IDLE);
    assign item_acc     = item_valid && !item_stall;
    assign cfg_ready    = 1'b1;
    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    assign mul_p = mul_a * mul_b;

    // edge b is the vertex just after a; skip_idx is the next ring's start
    assign b_idx    = v_reg + VCNT_W'(1);
    assign skip_idx = v_reg + VCNT_W'(2);
    assign last_idx = total_reg - VCNT_W'(1);

    // doubled vertex y coordinates, on the centre's scale
    assign ay2 = CTR_W'({a_reg.y, 1'b0});
    assign by2 = CTR_W'({rd_data.y, 1'b0});

    // intercept test, sign-corrected for the edge direction
    assign crossed = straddle_reg && (rising_reg ? (lhs_reg < rhs_reg)
                                                 : (lhs_reg > rhs_reg));

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_x_reg <= CELL_WIDTH_RESET;
            width_y_reg <= CELL_WIDTH_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_CELL_WIDTH_X: width_x_reg <= cfg_data;
                CFG_CELL_WIDTH_Y: width_y_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            total_reg     <= '0;
            ovf_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            total_reg     <= total_next;
            ovf_reg       <= ovf_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        ci_reg       <= ci_next;
        cj_reg       <= cj_next;
        cx_reg       <= cx_next;
        cy_reg       <= cy_next;
        v_reg        <= v_next;
        a_reg        <= a_next;
        start_reg    <= start_next;
        lhs_reg      <= lhs_next;
        rhs_reg      <= rhs_next;
        straddle_reg <= straddle_next;
        rising_reg   <= rising_next;
        count_reg    <= count_next;
        parity_reg   <= parity_next;
        res_reg      <= res_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        total_next     = total_reg;
        ovf_next       = ovf_reg;
        res_valid_next = res_valid_reg;
        res_next       = res_reg;
        ci_next        = ci_reg;
        cj_next        = cj_reg;
        cx_next        = cx_reg;
        cy_next        = cy_reg;
        v_next         = v_reg;
        a_next         = a_reg;
        start_next     = start_reg;
        lhs_next       = lhs_reg;
        rhs_next       = rhs_reg;
        straddle_next  = straddle_reg;
        rising_next    = rising_reg;
        count_next     = count_reg;
        parity_next    = parity_reg;

        wr_en   = 1'b0;
        wr_addr = total_reg[VIDX_W-1:0];
        wr_data = '{x: item.vertex_x, y: item.vertex_y};
        rd_en   = 1'b0;
        rd_addr = b_idx[VIDX_W-1:0];
        mul_a   = '0;
        mul_b   = '0;

        if (res_valid_reg && !result_stall)
        begin
            res_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_acc)
                begin
                    if (item.operation == OP_TEST)
                    begin
                        ci_next    = item.cell_i;
                        cj_next    = item.cell_j;
                        state_next = ST_CX;
                    end
                    else if (item.first_vertex)
                    begin
                        wr_en      = 1'b1;
                        wr_addr    = '0;
                        total_next = VCNT_W'(1);
                        ovf_next   = 1'b0;
                    end
                    else if (total_reg < VCNT_W'(MAX_VERTICES))
                    begin
                        wr_en      = 1'b1;
                        total_next = total_reg + VCNT_W'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                end
            end

            ST_CX:
            begin
                mul_a      = $signed(OPND_W'({ci_reg, 1'b1}));
                mul_b      = $signed(OPND_W'(width_x_reg));
                cx_next    = mul_p[CTR_W-1:0];
                state_next = ST_CY;
            end

            ST_CY:
            begin
                mul_a       = $signed(OPND_W'({cj_reg, 1'b1}));
                mul_b       = $signed(OPND_W'(width_y_reg));
                cy_next     = mul_p[CTR_W-1:0];
                count_next  = '0;
                parity_next = 1'b0;
                v_next      = '0;
                if (total_reg < VCNT_W'(2))
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = '0;
                    state_next = ST_RESTART;
                end
            end

            // ring start vertex has arrived; fetch the vertex after it
            ST_RESTART:
            begin
                a_next     = rd_data;
                start_next = rd_data;
                rd_en      = 1'b1;
                rd_addr    = b_idx[VIDX_W-1:0];
                state_next = ST_MUL_L;
            end

            // (cx - 2ax) * (by - ay)
            ST_MUL_L:
            begin
                mul_a = $signed(OPND_W'(cx_reg)) - $signed(OPND_W'({a_reg.x, 1'b0}));
                mul_b = $signed(OPND_W'(rd_data.y)) - $signed(OPND_W'(a_reg.y));
                lhs_next      = mul_p[PROD_W-1:0];
                straddle_next = (ay2 > cy_reg) != (by2 > cy_reg);
                rising_next   = rd_data.y > a_reg.y;
                state_next    = ST_MUL_R;
            end

            // (cy - 2ay) * (bx - ax)
            ST_MUL_R:
            begin
                mul_a = $signed(OPND_W'(cy_reg)) - $signed(OPND_W'({a_reg.y, 1'b0}));
                mul_b = $signed(OPND_W'(rd_data.x)) - $signed(OPND_W'(a_reg.x));
                rhs_next   = mul_p[PROD_W-1:0];
                state_next = ST_CMP;
            end

            ST_CMP:
            begin
                if (crossed)
                begin
                    parity_next = !parity_reg;
                    if (count_reg != COUNT_MAX)
                    begin
                        count_next = count_reg + COUNT_W'(1);
                    end
                end
                if (rd_data == start_reg)
                begin
                    // ring closed: skip the repeat, next ring starts after it
                    v_next = skip_idx;
                    if (skip_idx >= last_idx)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = skip_idx[VIDX_W-1:0];
                        state_next = ST_RESTART;
                    end
                end
                else
                begin
                    v_next = b_idx;
                    a_next = rd_data;
                    if (b_idx >= last_idx)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = skip_idx[VIDX_W-1:0];
                        state_next = ST_MUL_L;
                    end
                end
            end

            ST_DONE:
            begin
                if (!res_valid_reg || !result_stall)
                begin
                    res_valid_next          = 1'b1;
                    res_next.inside_res     = parity_reg;
                    res_next.crossing_count = count_reg;
                    res_next.list_overflow  = ovf_reg;
                    state_next              = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> test/polygon_cell_inclusion_test_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for polygon_cell_inclusion_test: a directed table, then random rings.
// Depends on pcit_pkg and the block's RTL only; prediction is done locally.

module polygon_cell_inclusion_test_test;
    import pcit_pkg::*;

    localparam int CLK_HALF     = 10;
    localparam int RESET_CYCLES = 10;
    // slowest test walks every edge of a full list
    localparam int DRAIN_CYCLES = 220;
    // long result hold-off, used once to back the block up
    localparam int HOLD_CYCLES  = 400;
    // cycles without any transaction before the run is declared hung
    localparam int STALL_LIMIT  = 4000;

    // register indexes that decode to nothing
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = CFG_IDX_W'(3);

    localparam logic [COORD_W-1:0] COORD_TOP = '1;
    localparam logic [CELL_W-1:0]  CELL_TOP  = '1;
    localparam logic [WIDTH_W-1:0] WIDTH_TOP = '1;

    typedef struct {
        item_t   it;
        bit      pinned;   // want holds a hand-typed result
        result_t want;
    } plan_row_t;

    // ------------------------------------------------------------------
    // Block-facing signals; those the bench drives are known from time zero
    // ------------------------------------------------------------------
    logic                 clk          = 1'b0;
    logic                 rst_n        = 1'b0;
    logic                 item_valid   = 1'b0;
    logic                 item_stall;
    item_t                item_word    = '0;
    logic                 result_valid;
    logic                 result_stall = 1'b0;
    result_t              result_word;
    logic                 cfg_valid    = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index    = '0;
    logic [WIDTH_W-1:0]   cfg_data     = '0;

    // a hand-typed result rides alongside the item it belongs to
    bit      pin_on  = 1'b0;
    result_t pin_res = '0;

    // ------------------------------------------------------------------
    // Local copy of the block's state, kept in step with accepted traffic
    // ------------------------------------------------------------------
    logic [WIDTH_W-1:0] width_x = CELL_WIDTH_RESET;
    logic [WIDTH_W-1:0] width_y = CELL_WIDTH_RESET;
    logic [COORD_W-1:0] ring_x [MAX_VERTICES];
    logic [COORD_W-1:0] ring_y [MAX_VERTICES];
    int unsigned        stored  = 0;
    bit                 dropped = 1'b0;

    result_t     verdict_q [$];   // results still owed by the block, oldest first
    int          errors     = 0;
    int          send_pct   = 0;  // chance per cycle that the sender sits idle
    int          recv_pct   = 0;  // chance per cycle that the receiver stalls
    bit          hold_req   = 1'b0;
    int unsigned items_sent = 0;

    always #CLK_HALF clk = ~clk;

    polygon_cell_inclusion_test dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item_word),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result_word),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Ray from the centre toward +x against edge a-b, all at doubled scale.
    // The intercept test is a cross-multiply whose sense flips with the
    // direction of the edge in y, so no division is needed.
    function automatic bit ray_crosses(longint cx, longint cy, longint ax, longint ay,
                                       longint bx, longint by);
        longint lhs;
        longint rhs;
        if (!((ay <= cy && by > cy) || (ay > cy && by <= cy)))
        begin
            return 1'b0;
        end
        lhs = (cx - ax) * (by - ay);
        rhs = (cy - ay) * (bx - ax);
        return (by > ay) ? (lhs < rhs) : (lhs > rhs);
    endfunction

    function automatic void store_vertex(item_t it);
        if (it.first_vertex)
        begin
            stored  = 0;
            dropped = 1'b0;
        end
        if (stored < MAX_VERTICES)
        begin
            ring_x[stored] = it.vertex_x;
            ring_y[stored] = it.vertex_y;
            stored++;
        end
        else
        begin
            dropped = 1'b1;
        end
    endfunction

    // Walks the stored rings. When the vertex just reached repeats the start
    // of its ring, that ring is closed and the next one begins a vertex later.
    function automatic result_t cell_verdict(logic [CELL_W-1:0] ci, logic [CELL_W-1:0] cj);
        longint      cx;
        longint      cy;
        int unsigned v;
        int unsigned ring_start;
        int unsigned hits;
        result_t     r;
        cx = (2 * longint'(ci) + 1) * longint'(width_x);
        cy = (2 * longint'(cj) + 1) * longint'(width_y);
        v = 0;
        ring_start = 0;
        hits = 0;
        while (stored >= 2 && v < stored - 1)
        begin
            if (ray_crosses(cx, cy, 2 * longint'(ring_x[v]), 2 * longint'(ring_y[v]),
                            2 * longint'(ring_x[v + 1]), 2 * longint'(ring_y[v + 1])))
            begin
                hits++;
            end
            v++;
            if (ring_x[v] == ring_x[ring_start] && ring_y[v] == ring_y[ring_start])
            begin
                v++;
                ring_start = v;
                if (ring_start >= stored)
                begin
                    break;
                end
            end
        end
        r.inside_res     = hits[0];
        r.crossing_count = (hits > COUNT_MAX) ? COUNT_MAX : COUNT_W'(hits);
        r.list_overflow  = dropped;
        return r;
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            errors++;
        end
    endfunction

    // ------------------------------------------------------------------
    // Monitor: samples pre-edge values at every rising edge
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_CELL_WIDTH_X)
                begin
                    width_x = cfg_data;
                end
                else if (cfg_index == CFG_CELL_WIDTH_Y)
                begin
                    width_y = cfg_data;
                end
            end
            if (item_valid && !item_stall)
            begin
                if (item_word.operation == OP_TEST)
                begin
                    verdict_q.push_back(pin_on ? pin_res
                                               : cell_verdict(item_word.cell_i, item_word.cell_j));
                end
                else
                begin
                    store_vertex(item_word);
                end
            end
            if (result_valid && !result_stall)
            begin
                if (verdict_q.size() == 0)
                begin
                    $display("%0t: result transaction with none owed, got %p", $time, result_word);
                    errors++;
                end
                else
                begin
                    want = verdict_q.pop_front();
                    check_field("inside_res", want.inside_res, result_word.inside_res);
                    check_field("crossing_count", want.crossing_count,
                                result_word.crossing_count);
                    check_field("list_overflow", want.list_overflow, result_word.list_overflow);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random stalls, or one long hold-off counted here on request
    // ------------------------------------------------------------------
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                result_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            result_stall <= ($urandom_range(99) < recv_pct);
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: ends a run that stops moving
    // ------------------------------------------------------------------
    initial
    begin
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((item_valid && !item_stall) || (result_valid && !result_stall)
                || (cfg_valid && cfg_ready))
            begin
                quiet = 0;
            end
            else
            begin
                quiet++;
            end
        end
        $display("%0t: no transaction for %0d cycles, %0d results owed", $time, STALL_LIMIT,
                 verdict_q.size());
        $display("polygon_cell_inclusion_test_test: errors");
        $finish;
    end

    // ------------------------------------------------------------------
    // Item builders; fields a given operation ignores are filled at random
    // ------------------------------------------------------------------
    function automatic item_t load_item(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                                        logic first);
        item_t it;
        it.operation    = OP_LOAD;
        it.vertex_x     = x;
        it.vertex_y     = y;
        it.first_vertex = first;
        it.cell_i       = CELL_W'($urandom());
        it.cell_j       = CELL_W'($urandom());
        return it;
    endfunction

    function automatic item_t test_item(logic [CELL_W-1:0] ci, logic [CELL_W-1:0] cj);
        item_t it;
        it.operation    = OP_TEST;
        it.vertex_x     = COORD_W'($urandom());
        it.vertex_y     = COORD_W'($urandom());
        it.first_vertex = 1'($urandom_range(1));
        it.cell_i       = ci;
        it.cell_j       = cj;
        return it;
    endfunction

    function automatic result_t tally(logic ins, int unsigned cnt);
        result_t r;
        r.inside_res     = ins;
        r.crossing_count = COUNT_W'(cnt);
        r.list_overflow  = 1'b0;
        return r;
    endfunction

    // Coordinate in a region of a few cells; a third land exactly on a row or
    // column of centres so that vertices and edges meet the ray head on.
    function automatic logic [COORD_W-1:0] pick_coord(logic [WIDTH_W-1:0] pitch,
                                                      int unsigned cells);
        longint unsigned pitch_u;
        longint unsigned v;
        pitch_u = (pitch == 0) ? 1 : pitch;
        if ($urandom_range(2) == 0)
        begin
            v = pitch_u * $urandom_range(cells) + pitch_u / 2;
        end
        else
        begin
            v = $urandom_range(32'(pitch_u * (cells + 1)));
        end
        if (v > COORD_TOP)
        begin
            v = COORD_TOP;
        end
        return COORD_W'(v);
    endfunction

    function automatic logic [CELL_W-1:0] pick_cell(int unsigned cells);
        if ($urandom_range(9) == 0)
        begin
            return CELL_W'($urandom());
        end
        return CELL_W'($urandom_range(cells + 1));
    endfunction

    // ------------------------------------------------------------------
    // Driving tasks; every one is entered and left at a rising edge
    // ------------------------------------------------------------------

    // Valid stays high on return so back-to-back items keep it up without a
    // second assignment in the same step.
    task automatic offer(input item_t it, input bit pinned, input result_t want);
        while ($urandom_range(99) < send_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_word  <= it;
        pin_on     <= pinned;
        pin_res    <= want;
        item_valid <= 1'b1;
        @(posedge clk);
        while (item_stall)
        begin
            @(posedge clk);
        end
        items_sent++;
    endtask

    // Stops offering, waits for every owed result, then lets the block go idle.
    task automatic settle();
        item_valid <= 1'b0;
        @(posedge clk);
        while (verdict_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Drops cfg_valid after the write and idles before returning, so that back-to-back
    // writes never drive cfg_valid twice in one step.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WIDTH_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Mostly closed rings with random corners followed by a few cell tests;
    // now and then an open ring, a list run past capacity, or pure noise.
    task automatic run_random(input int unsigned quota, input bit start_full);
        int unsigned        stop_at;
        int unsigned        pick;
        int unsigned        rings;
        int unsigned        corners;
        int unsigned        span_x;
        int unsigned        span_y;
        logic [COORD_W-1:0] sx;
        logic [COORD_W-1:0] sy;
        stop_at = items_sent + quota;
        while (items_sent < stop_at)
        begin
            pick   = start_full ? 1 : $urandom_range(15);
            span_x = $urandom_range(40, 2);
            span_y = $urandom_range(40, 2);
            start_full = 1'b0;
            if (pick == 0)
            begin
                if ($urandom_range(1))
                begin
                    offer(load_item(COORD_W'($urandom()), COORD_W'($urandom()),
                                    1'($urandom_range(1))), 1'b0, '0);
                end
                else
                begin
                    offer(test_item(CELL_W'($urandom()), CELL_W'($urandom())), 1'b0, '0);
                end
            end
            else
            begin
                if (pick == 1)
                begin
                    // more vertices than fit: the tail is dropped and flagged
                    corners = $urandom_range(70, 66);
                    for (int k = 0; k < corners; k++)
                    begin
                        offer(load_item(pick_coord(width_x, span_x), pick_coord(width_y, span_y),
                                        k == 0), 1'b0, '0);
                    end
                end
                else
                begin
                    rings = $urandom_range(3, 1);
                    for (int r = 0; r < rings; r++)
                    begin
                        corners = $urandom_range(7, 3);
                        sx = pick_coord(width_x, span_x);
                        sy = pick_coord(width_y, span_y);
                        offer(load_item(sx, sy, r == 0 && $urandom_range(7) != 0), 1'b0, '0);
                        for (int k = 1; k < corners; k++)
                        begin
                            offer(load_item(pick_coord(width_x, span_x),
                                            pick_coord(width_y, span_y), 1'b0), 1'b0, '0);
                        end
                        if ($urandom_range(5) != 0)
                        begin
                            offer(load_item(sx, sy, 1'b0), 1'b0, '0);
                        end
                    end
                end
                repeat ($urandom_range(6, 2))
                begin
                    offer(test_item(pick_cell(span_x), pick_cell(span_y)), 1'b0, '0);
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence of the run
    // ------------------------------------------------------------------
    initial
    begin
        plan_row_t plan [$];

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table, spacing still at its reset value of 1 m (256).
        // Empty list, then a single vertex: no edge to walk.
        plan.push_back('{test_item(0, 0), 1'b1, tally(1'b0, 0)});
        plan.push_back('{load_item(256, 256, 1'b1), 1'b0, '0});
        plan.push_back('{test_item(1, 1), 1'b1, tally(1'b0, 0)});
        // Square from 1 m to 3 m, closed on its first corner.
        plan.push_back('{load_item(768, 256, 1'b0), 1'b0, '0});
        plan.push_back('{load_item(768, 768, 1'b0), 1'b0, '0});
        plan.push_back('{load_item(256, 768, 1'b0), 1'b0, '0});
        plan.push_back('{load_item(256, 256, 1'b0), 1'b0, '0});
        plan.push_back('{test_item(1, 1), 1'b1, tally(1'b1, 1)});
        plan.push_back('{test_item(0, 0), 1'b1, tally(1'b0, 0)});
        // centre left of the square: both vertical sides cross the ray
        plan.push_back('{test_item(0, 1), 1'b1, tally(1'b0, 2)});
        plan.push_back('{test_item(CELL_TOP, CELL_TOP), 1'b1, tally(1'b0, 0)});
        // Second ring, a hole whose corner sits on a cell centre.
        plan.push_back('{load_item(384, 384, 1'b0), 1'b0, '0});
        plan.push_back('{load_item(640, 384, 1'b0), 1'b0, '0});
        plan.push_back('{load_item(640, 640, 1'b0), 1'b0, '0});
        plan.push_back('{load_item(384, 640, 1'b0), 1'b0, '0});
        plan.push_back('{load_item(384, 384, 1'b0), 1'b0, '0});
        plan.push_back('{test_item(1, 1), 1'b0, '0});
        plan.push_back('{test_item(2, 2), 1'b0, '0});
        // Restart with an open ring at the coordinate extremes.
        plan.push_back('{load_item(0, 0, 1'b1), 1'b0, '0});
        plan.push_back('{load_item(COORD_TOP, 0, 1'b0), 1'b0, '0});
        plan.push_back('{load_item(COORD_TOP, COORD_TOP, 1'b0), 1'b0, '0});
        plan.push_back('{load_item(0, COORD_TOP, 1'b0), 1'b0, '0});
        plan.push_back('{test_item(0, 0), 1'b0, '0});
        plan.push_back('{test_item(CELL_TOP, CELL_TOP), 1'b0, '0});
        foreach (plan[k])
        begin
            offer(plan[k].it, plan[k].pinned, plan[k].want);
        end
        settle();

        // Reset spacing, no idling; starts with an over-full list.
        send_pct = 0;
        recv_pct = 0;
        run_random(45, 1'b1);

        // Receiver holds off while tests keep coming: the block fills and
        // stalls its input. Then the sender waits until all results are in.
        hold_req = 1'b1;
        repeat (4)
        begin
            offer(test_item(pick_cell(8), pick_cell(8)), 1'b0, '0);
        end
        settle();

        // Finest grid, sender mostly idle.
        write_reg(CFG_CELL_WIDTH_X, WIDTH_W'(1));
        write_reg(CFG_CELL_WIDTH_Y, WIDTH_W'(1));
        send_pct = 77;
        recv_pct = 0;
        run_random(45, 1'b0);
        settle();

        // Coarsest grid, receiver mostly stalling.
        write_reg(CFG_CELL_WIDTH_X, WIDTH_TOP);
        write_reg(CFG_CELL_WIDTH_Y, WIDTH_TOP);
        send_pct = 0;
        recv_pct = 77;
        run_random(45, 1'b1);
        settle();

        // Zero spacing in x puts every centre on x = 0; writes to the spare
        // indexes must leave both spacings alone.
        write_reg(CFG_CELL_WIDTH_X, '0);
        write_reg(CFG_CELL_WIDTH_Y, WIDTH_W'($urandom_range(65535, 1)));
        write_reg(CFG_SPARE_A, WIDTH_W'($urandom()));
        write_reg(CFG_SPARE_B, WIDTH_W'($urandom()));
        send_pct = 13;
        recv_pct = 13;
        run_random(55, 1'b0);
        settle();

        // Zero spacing in y, no idling.
        write_reg(CFG_CELL_WIDTH_X, WIDTH_W'($urandom_range(65535, 1)));
        write_reg(CFG_CELL_WIDTH_Y, '0);
        send_pct = 0;
        recv_pct = 0;
        run_random(45, 1'b0);
        settle();

        // Arbitrary spacings, light idling on both sides.
        write_reg(CFG_CELL_WIDTH_X, WIDTH_W'($urandom_range(65535, 1)));
        write_reg(CFG_CELL_WIDTH_Y, WIDTH_W'($urandom_range(65535, 1)));
        send_pct = 13;
        recv_pct = 13;
        run_random(45, 1'b0);
        settle();

        if (verdict_q.size() != 0)
        begin
            $display("%0t: %0d results never arrived", $time, verdict_q.size());
            errors++;
        end
        if (errors == 0)
        begin
            $display("polygon_cell_inclusion_test_test: clean");
        end
        else
        begin
            $display("polygon_cell_inclusion_test_test: errors");
        end
        $finish;
    end

endmodule

>>> filelist.f
sv/pcit_pkg.sv
sv/pcit_ram.sv
sv/polygon_cell_inclusion_test.sv
test/polygon_cell_inclusion_test_test.sv
